[design/prqs_pkg.sv]
// Shared types, codes and helpers for the priority ready-queue scheduler.
// No dependencies.
`default_nettype none
package prqs_pkg;

   localparam int ID_W  = 5;
   localparam int LVL_W = 5;

   typedef enum logic [2:0] {
      OP_ENQUEUE   = 3'd0,
      OP_DEQUEUE   = 3'd1,
      OP_YIELD     = 3'd2,
      OP_SELECT    = 3'd3,
      OP_SET_LEVEL = 3'd4,
      OP_THRESHOLD = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_NO_EFFECT = 3'd1,
      ST_NOT_RUN   = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_BAD_THR   = 3'd4
   } status_type;

   // Bit 31 stands for level 0.
   function automatic logic [31:0] level_bit(input logic [LVL_W-1:0] lvl);
      level_bit = 32'h8000_0000 >> lvl;
   endfunction

   // Number of leading zeros, 32 for an empty mask.
   function automatic logic [5:0] lead_zeros(input logic [31:0] mask);
      logic [5:0] n;
      n = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (mask[i]) begin
            n = 6'(31 - i);
         end
      end
      lead_zeros = n;
   endfunction

endpackage
`default_nettype wire

[design/prqs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module prqs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

[design/priority_ready_queue_scheduler.sv]
// Priority ready-queue scheduler: one operation at a time, rings kept in RAMs.
// A ring insertion into a non-empty level reads the head and then the tail before it
// writes the new links; a removal rewrites the neighbours' links directly.
// Throughput: the next item is accepted in the cycle after the result is taken.
// Reset (synchronous) clears the masks and queued flags; thread attributes read as
// the idle level until written, so there is no clearing pass.
// Depends on prqs_pkg and prqs_ram.
`default_nettype none
module priority_ready_queue_scheduler
   import prqs_pkg::*;
#(
   parameter int LEVELS  = 32,
   parameter int THREADS = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [2:0]   req_opcode,
   input  wire logic [4:0]   req_thread_id,
   input  wire logic [4:0]   req_current_id,
   input  wire logic         req_current_valid,
   input  wire logic         req_runnable,
   input  wire logic [7:0]   req_new_level,
   input  wire logic [4:0]   req_user_level,
   input  wire logic [4:0]   req_inherited_level,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [4:0]        rsp_chosen_id,
   output logic [4:0]        rsp_old_user_threshold,
   output logic              rsp_need_reschedule,
   output logic [31:0]       rsp_ready_levels,
   output logic [31:0]       rsp_deferred_levels
);
   localparam int TW = $clog2(THREADS);
   localparam int HW = $clog2(LEVELS);
   localparam int AW = 3 * LVL_W;
   localparam logic [LVL_W-1:0] IDLE = LVL_W'(LEVELS - 1);
   localparam logic [31:0] LVL_MASK = ~(32'hFFFF_FFFF >> LEVELS);

   typedef enum logic [3:0] {
      S_IDLE, S_ATTR, S_REM, S_INS0, S_INS1, S_INS2, S_INS3, S_Y1, S_Y2, S_RESP
   } state_type;

   state_type state_ff;
   op_type op_ff;
   logic [ID_W-1:0] tid_ff, cur_ff, h_ff, tail_ff, chosen_ff, old_ff;
   logic tok_ff, cok_ff, run_ff, av_rd_ff, resched_ff, rsp_valid_ff;
   logic [7:0] nl_ff;
   logic [LVL_W-1:0] ul_ff, il_ff, lvl_ff;
   logic [5:0] top_ff;
   logic [AW-1:0] attr_ff;
   logic [31:0] ready_ff, preempt_ff;
   logic [THREADS-1:0] queued_ff, av_ff;
   status_type status_ff;

   logic hd_we, hd_re, nx_we, nx_re, pv_we, pv_re, at_we;
   logic [HW-1:0] hd_wa, hd_ra;
   logic [TW-1:0] nx_wa, nx_ra, pv_wa, pv_ra, at_wa, at_ra;
   logic [ID_W-1:0] hd_wd, hd_rd, nx_wd, nx_rd, pv_wd, pv_rd;
   logic [AW-1:0] at_wd, at_rd;

   prqs_ram #(.WIDTH(ID_W), .DEPTH(LEVELS)) u_head (
      .clock, .wr_en(hd_we), .wr_addr(hd_wa), .wr_data(hd_wd),
      .rd_en(hd_re), .rd_addr(hd_ra), .rd_data(hd_rd));
   prqs_ram #(.WIDTH(ID_W), .DEPTH(THREADS)) u_next (
      .clock, .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_en(nx_re), .rd_addr(nx_ra), .rd_data(nx_rd));
   prqs_ram #(.WIDTH(ID_W), .DEPTH(THREADS)) u_prev (
      .clock, .wr_en(pv_we), .wr_addr(pv_wa), .wr_data(pv_wd),
      .rd_en(pv_re), .rd_addr(pv_ra), .rd_data(pv_rd));
   prqs_ram #(.WIDTH(AW), .DEPTH(THREADS)) u_attr (
      .clock, .wr_en(at_we), .wr_addr(at_wa), .wr_data(at_wd),
      .rd_en(req_valid && !req_stall), .rd_addr(at_ra), .rd_data(at_rd));

   logic accept;
   logic [TW-1:0] t_a, c_a;
   logic [AW-1:0] attr_q;
   logic [LVL_W-1:0] a_lvl, a_eff, a_usr, newl, eff;
   logic qt, qc, do_rem, do_yield, at_attr_wr, thr_ok, keep_cur;
   logic [5:0] ready_lz;
   state_type attr_next;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign t_a = TW'(tid_ff);
   assign c_a = TW'(cur_ff);
   assign attr_q = av_rd_ff ? at_rd : {IDLE, IDLE, IDLE};
   assign a_lvl = attr_q[AW-1 -: LVL_W];
   assign a_eff = attr_q[LVL_W +: LVL_W];
   assign a_usr = attr_q[LVL_W-1:0];
   assign newl = (nl_ff < 8'(LEVELS)) ? nl_ff[LVL_W-1:0] : IDLE;
   assign eff = (nl_ff[LVL_W-1:0] < il_ff) ? nl_ff[LVL_W-1:0] : il_ff;
   assign qt = queued_ff[t_a];
   assign qc = queued_ff[c_a];
   assign ready_lz = lead_zeros(ready_ff);
   assign thr_ok = tok_ff && (nl_ff <= {3'b000, ul_ff});
   assign keep_cur = cok_ff && run_ff && (cur_ff != hd_rd) && (top_ff >= {1'b0, a_eff});

   // Decisions taken once the attribute word is back.
   always_comb begin
      do_rem = 1'b0;
      do_yield = 1'b0;
      at_attr_wr = 1'b0;
      case (op_ff)
         OP_DEQUEUE: do_rem = tok_ff && qt;
         OP_YIELD: do_yield = cok_ff && qc && ((ready_ff & level_bit(a_lvl)) != 32'd0);
         OP_SET_LEVEL: begin
            do_rem = tok_ff && (a_lvl != newl) && qt && run_ff;
            at_attr_wr = tok_ff && (a_lvl != newl) && !qt;
         end
         OP_THRESHOLD: at_attr_wr = thr_ok;
         default: ;
      endcase
   end

   assign attr_next = do_rem ? S_REM :
                      do_yield ? S_Y1 :
                      (op_ff == OP_ENQUEUE && tok_ff && run_ff && !qt) ? S_INS0 : S_RESP;

   always_comb begin
      hd_we = 1'b0; hd_wa = HW'(lvl_ff); hd_wd = tid_ff;
      hd_re = 1'b0; hd_ra = HW'(lvl_ff);
      nx_we = 1'b0; nx_wa = t_a; nx_wd = tid_ff; nx_re = 1'b0; nx_ra = t_a;
      pv_we = 1'b0; pv_wa = t_a; pv_wd = tid_ff; pv_re = 1'b0; pv_ra = t_a;
      at_we = 1'b0; at_wa = t_a; at_wd = attr_ff;
      at_ra = (op_type'(req_opcode) == OP_YIELD || op_type'(req_opcode) == OP_SELECT)
              ? TW'(req_current_id) : TW'(req_thread_id);
      case (state_ff)
         S_IDLE: begin
            hd_re = accept && (op_type'(req_opcode) == OP_SELECT);
            hd_ra = HW'(lead_zeros(ready_ff));
         end
         S_ATTR: begin
            hd_ra = HW'(a_lvl);
            hd_re = do_rem || do_yield;
            nx_re = do_rem;
            pv_re = do_rem;
            at_we = at_attr_wr;
            at_wd = (op_ff == OP_THRESHOLD) ? {a_lvl, eff, nl_ff[LVL_W-1:0]}
                                            : {newl, a_eff, a_usr};
         end
         S_REM: begin
            if (nx_rd != tid_ff) begin
               nx_we = 1'b1; nx_wa = TW'(pv_rd); nx_wd = nx_rd;
               pv_we = 1'b1; pv_wa = TW'(nx_rd); pv_wd = pv_rd;
               hd_we = (hd_rd == tid_ff); hd_wd = nx_rd;
            end
            at_we = (op_ff == OP_SET_LEVEL);
            at_wd = {newl, attr_ff[2*LVL_W-1:0]};
         end
         S_INS0: begin
            if ((ready_ff & level_bit(lvl_ff)) == 32'd0) begin
               hd_we = 1'b1; nx_we = 1'b1; pv_we = 1'b1;
            end else begin
               hd_re = 1'b1;
            end
         end
         S_INS1: begin
            pv_re = 1'b1; pv_ra = TW'(hd_rd);
         end
         S_INS2: begin
            nx_we = 1'b1; nx_wd = h_ff;
            pv_we = 1'b1; pv_wd = pv_rd;
         end
         S_INS3: begin
            nx_we = 1'b1; nx_wa = TW'(tail_ff);
            pv_we = 1'b1; pv_wa = TW'(h_ff);
         end
         S_Y1: begin
            nx_re = 1'b1; nx_ra = TW'(hd_rd);
         end
         S_Y2: begin
            hd_we = (nx_rd != h_ff); hd_wd = nx_rd;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ready_ff <= '0;
         preempt_ff <= '0;
         queued_ff <= '0;
         av_ff <= '0;
      end else begin
         if (at_we) begin
            av_ff[at_wa] <= 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff <= op_type'(req_opcode);
                  tid_ff <= req_thread_id;
                  cur_ff <= req_current_id;
                  tok_ff <= 32'(req_thread_id) < THREADS;
                  cok_ff <= req_current_valid && (32'(req_current_id) < THREADS);
                  run_ff <= req_runnable;
                  nl_ff <= req_new_level;
                  ul_ff <= req_user_level;
                  il_ff <= req_inherited_level;
                  top_ff <= lead_zeros(ready_ff);
                  av_rd_ff <= av_ff[at_ra];
                  status_ff <= ST_NO_EFFECT;
                  chosen_ff <= '0;
                  old_ff <= '0;
                  resched_ff <= 1'b0;
                  state_ff <= S_ATTR;
               end
            end
            S_ATTR: begin
               lvl_ff <= a_lvl;
               attr_ff <= attr_q;
               state_ff <= attr_next;
               rsp_valid_ff <= (attr_next == S_RESP);
               case (op_ff)
                  OP_ENQUEUE: begin
                     if (tok_ff && !run_ff) begin
                        status_ff <= ST_NOT_RUN;
                     end
                  end
                  OP_SELECT: begin
                     if (top_ff >= 6'(LEVELS)) begin
                        status_ff <= ST_EMPTY;
                     end else begin
                        status_ff <= ST_OK;
                        if (keep_cur) begin
                           chosen_ff <= cur_ff;
                           if (a_eff != a_lvl) begin
                              preempt_ff <= preempt_ff | level_bit(a_lvl);
                           end
                        end else begin
                           chosen_ff <= hd_rd;
                           preempt_ff <= preempt_ff & ~level_bit(top_ff[LVL_W-1:0]);
                        end
                     end
                  end
                  OP_SET_LEVEL: begin
                     if (at_attr_wr) begin
                        status_ff <= ST_OK;
                     end else if (tok_ff && (a_lvl != newl) && !do_rem) begin
                        status_ff <= ST_NOT_RUN;
                     end
                  end
                  OP_THRESHOLD: begin
                     if (thr_ok) begin
                        status_ff <= ST_OK;
                        old_ff <= a_usr;
                        if (cok_ff && (cur_ff == tid_ff) && (eff > a_usr)) begin
                           if (ready_lz < {1'b0, eff}) begin
                              resched_ff <= 1'b1;
                              preempt_ff <= preempt_ff & ~level_bit(a_lvl);
                           end else if (eff == a_lvl) begin
                              preempt_ff <= preempt_ff & ~level_bit(a_lvl);
                           end
                        end
                     end else if (tok_ff) begin
                        status_ff <= ST_BAD_THR;
                     end
                  end
                  default: ;
               endcase
            end
            S_REM: begin
               if (nx_rd == tid_ff) begin
                  ready_ff <= ready_ff & ~level_bit(lvl_ff);
               end
               queued_ff[t_a] <= 1'b0;
               if (op_ff == OP_SET_LEVEL) begin
                  lvl_ff <= newl;
                  state_ff <= S_INS0;
               end else begin
                  status_ff <= ST_OK;
                  state_ff <= S_RESP;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_INS0: begin
               if ((ready_ff & level_bit(lvl_ff)) == 32'd0) begin
                  ready_ff <= ready_ff | level_bit(lvl_ff);
                  queued_ff[t_a] <= 1'b1;
                  status_ff <= ST_OK;
                  state_ff <= S_RESP;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= S_INS1;
               end
            end
            S_INS1: begin
               h_ff <= hd_rd;
               state_ff <= S_INS2;
            end
            S_INS2: begin
               tail_ff <= pv_rd;
               state_ff <= S_INS3;
            end
            S_INS3: begin
               queued_ff[t_a] <= 1'b1;
               status_ff <= ST_OK;
               state_ff <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_Y1: begin
               h_ff <= hd_rd;
               state_ff <= S_Y2;
            end
            S_Y2: begin
               if (nx_rd != h_ff) begin
                  status_ff <= ST_OK;
               end
               state_ff <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_chosen_id = chosen_ff;
   assign rsp_old_user_threshold = old_ff;
   assign rsp_need_reschedule = resched_ff;
   assign rsp_ready_levels = ready_ff;
   assign rsp_deferred_levels = preempt_ff;

   a_resp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_RESP)
      else $error("result offered outside the response state");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_ATTR && !rsp_valid_ff)
      else $error("accepted item did not start its operation");
   a_ready_range: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & ~LVL_MASK) == 32'd0 && (preempt_ff & ~LVL_MASK) == 32'd0)
      else $error("mask bit set for a level that does not exist");
   a_resched_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && resched_ff |-> status_ff == ST_OK)
      else $error("reschedule flagged on a failed operation");
endmodule
`default_nettype wire

[tb/priority_ready_queue_scheduler_tb.sv]
// Self-checking testbench for the priority ready-queue scheduler.
// Holds a behavioural copy of the scheduler state and checks every result item.
// Depends on prqs_pkg and the priority_ready_queue_scheduler RTL.
`default_nettype none
module priority_ready_queue_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import prqs_pkg::*;

   localparam int NUM_LEVELS  = 32;
   localparam int NUM_THREADS = 32;
   localparam int IDLE        = NUM_LEVELS - 1;
   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      logic [2:0] opcode;
      logic [4:0] thread_id;
      logic [4:0] current_id;
      logic       current_valid;
      logic       runnable;
      logic [7:0] new_level;
      logic [4:0] user_level;
      logic [4:0] inherited_level;
   } sched_req_t;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  chosen_id;
      logic [4:0]  old_user_threshold;
      logic        need_reschedule;
      logic [31:0] ready_levels;
      logic [31:0] deferred_levels;
   } sched_rsp_t;

   // One row of the directed table; has_fixed marks a hand-written expectation.
   typedef struct {
      sched_req_t req;
      bit         has_fixed;
      sched_rsp_t fixed;
   } directed_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [4:0] req_thread_id = '0;
   logic [4:0] req_current_id = '0;
   logic req_current_valid = 1'b0;
   logic req_runnable = 1'b0;
   logic [7:0] req_new_level = '0;
   logic [4:0] req_user_level = '0;
   logic [4:0] req_inherited_level = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [4:0] rsp_chosen_id;
   logic [4:0] rsp_old_user_threshold;
   logic rsp_need_reschedule;
   logic [31:0] rsp_ready_levels;
   logic [31:0] rsp_deferred_levels;

   priority_ready_queue_scheduler dut (.*);

   always #10 clock = ~clock;

   // Scheduler shadow state.
   logic [31:0] shadow_ready;
   logic [31:0] shadow_deferred;
   logic [4:0]  shadow_head [NUM_LEVELS];
   logic [4:0]  shadow_next [NUM_THREADS];
   logic [4:0]  shadow_prev [NUM_THREADS];
   bit          shadow_queued [NUM_THREADS];
   logic [4:0]  shadow_level [NUM_THREADS];
   logic [4:0]  shadow_eff_thr [NUM_THREADS];
   logic [4:0]  shadow_user_thr [NUM_THREADS];

   sched_rsp_t expected_rsps [$];
   int mismatches = 0;
   int cycles = 0;
   bit hold_off = 1'b0;
   directed_row_t directed [$];

   function automatic logic [31:0] lvl_mask(input logic [4:0] lvl);
      return 32'h8000_0000 >> lvl;
   endfunction

   function automatic int top_level(input logic [31:0] mask);
      for (int i = 0; i < 32; i++) begin
         if (mask[31 - i]) begin
            return i;
         end
      end
      return 32;
   endfunction

   task automatic ring_link(input logic [4:0] t);
      logic [4:0] lvl;
      logic [4:0] h;
      logic [4:0] tail;
      lvl = shadow_level[t];
      if (!(shadow_ready & lvl_mask(lvl))) begin
         shadow_head[lvl] = t;
         shadow_next[t] = t;
         shadow_prev[t] = t;
         shadow_ready |= lvl_mask(lvl);
      end else begin
         h = shadow_head[lvl];
         tail = shadow_prev[h];
         shadow_next[t] = h;
         shadow_prev[t] = tail;
         shadow_next[tail] = t;
         shadow_prev[h] = t;
      end
      shadow_queued[t] = 1'b1;
   endtask

   task automatic ring_unlink(input logic [4:0] t);
      logic [4:0] lvl;
      logic [4:0] p;
      logic [4:0] n;
      lvl = shadow_level[t];
      p = shadow_prev[t];
      n = shadow_next[t];
      if (n == t) begin
         shadow_ready &= ~lvl_mask(lvl);
      end else begin
         shadow_next[p] = n;
         shadow_prev[n] = p;
         if (shadow_head[lvl] == t) begin
            shadow_head[lvl] = n;
         end
      end
      shadow_queued[t] = 1'b0;
   endtask

   task automatic schedule_predict(input sched_req_t r, output sched_rsp_t o);
      logic [4:0] t;
      logic [4:0] cur;
      logic [4:0] lvl;
      logic [4:0] cand;
      logic [4:0] prev_thr;
      logic [4:0] eff;
      bit cur_ok;
      int top;
      t = r.thread_id;
      cur = r.current_id;
      cur_ok = r.current_valid;
      o = '0;
      o.status = ST_NO_EFFECT;
      case (r.opcode)
         OP_ENQUEUE: begin
            if (!r.runnable) begin
               o.status = ST_NOT_RUN;
            end else if (!shadow_queued[t]) begin
               ring_link(t);
               o.status = ST_OK;
            end
         end
         OP_DEQUEUE: begin
            if (shadow_queued[t]) begin
               ring_unlink(t);
               o.status = ST_OK;
            end
         end
         OP_YIELD: begin
            if (cur_ok && shadow_queued[cur]) begin
               lvl = shadow_level[cur];
               if (shadow_ready & lvl_mask(lvl)) begin
                  cand = shadow_head[lvl];
                  if (shadow_next[cand] != cand) begin
                     shadow_head[lvl] = shadow_next[cand];
                     o.status = ST_OK;
                  end
               end
            end
         end
         OP_SELECT: begin
            top = top_level(shadow_ready);
            if (top >= NUM_LEVELS) begin
               o.status = ST_EMPTY;
            end else begin
               cand = shadow_head[top];
               o.status = ST_OK;
               if (cur_ok && r.runnable && cur != cand && top >= shadow_eff_thr[cur]) begin
                  // The running thread keeps the processor under its threshold.
                  if (shadow_eff_thr[cur] != shadow_level[cur]) begin
                     shadow_deferred |= lvl_mask(shadow_level[cur]);
                  end
                  o.chosen_id = cur;
               end else begin
                  shadow_deferred &= ~lvl_mask(5'(top));
                  o.chosen_id = cand;
               end
            end
         end
         OP_SET_LEVEL: begin
            lvl = (r.new_level < NUM_LEVELS) ? r.new_level[4:0] : 5'(IDLE);
            if (shadow_level[t] != lvl) begin
               if (shadow_queued[t]) begin
                  if (!r.runnable) begin
                     o.status = ST_NOT_RUN;
                  end else begin
                     ring_unlink(t);
                     shadow_level[t] = lvl;
                     ring_link(t);
                     o.status = ST_OK;
                  end
               end else begin
                  shadow_level[t] = lvl;
                  o.status = ST_OK;
               end
            end
         end
         OP_THRESHOLD: begin
            if (r.new_level > r.user_level) begin
               o.status = ST_BAD_THR;
            end else begin
               prev_thr = shadow_user_thr[t];
               eff = (r.new_level[4:0] < r.inherited_level) ? r.new_level[4:0]
                                                           : r.inherited_level;
               shadow_eff_thr[t] = eff;
               shadow_user_thr[t] = r.new_level[4:0];
               if (cur_ok && cur == t && eff > prev_thr) begin
                  if (top_level(shadow_ready) < eff) begin
                     o.need_reschedule = 1'b1;
                     shadow_deferred &= ~lvl_mask(shadow_level[t]);
                  end else if (eff == shadow_level[t]) begin
                     shadow_deferred &= ~lvl_mask(shadow_level[t]);
                  end
               end
               o.old_user_threshold = prev_thr;
               o.status = ST_OK;
            end
         end
         default: ;
      endcase
      o.ready_levels = shadow_ready;
      o.deferred_levels = shadow_deferred;
   endtask

   function automatic sched_req_t make_req(input op_type op, input int t, input int cur,
                                           input bit cv, input bit run, input int nl,
                                           input int ul, input int il);
      sched_req_t r;
      r.opcode = op;
      r.thread_id = 5'(t);
      r.current_id = 5'(cur);
      r.current_valid = cv;
      r.runnable = run;
      r.new_level = 8'(nl);
      r.user_level = 5'(ul);
      r.inherited_level = 5'(il);
      return r;
   endfunction

   task automatic add_row(input sched_req_t r, input bit fixed_ok, input sched_rsp_t f);
      directed_row_t row;
      row.req = r;
      row.has_fixed = fixed_ok;
      row.fixed = f;
      directed.push_back(row);
   endtask

   function automatic sched_rsp_t fixed_rsp(input status_type st, input int chosen,
                                            input logic [31:0] rdy);
      sched_rsp_t f;
      f = '0;
      f.status = st;
      f.chosen_id = 5'(chosen);
      f.ready_levels = rdy;
      return f;
   endfunction

   // Drive one item at the falling edge and hold it until it is taken.
   task automatic send_item(input sched_req_t r, input bit fixed_ok, input sched_rsp_t f);
      sched_rsp_t predicted;
      schedule_predict(r, predicted);
      if (fixed_ok && predicted !== f) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("directed row disagrees: table %h, predicted %h", f, predicted);
         end
      end
      expected_rsps.push_back(predicted);
      req_valid <= 1'b1;
      {req_opcode, req_thread_id, req_current_id, req_current_valid, req_runnable,
       req_new_level, req_user_level, req_inherited_level} <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   function automatic sched_req_t random_req();
      sched_req_t r;
      int pick;
      r = sched_req_t'($bits(sched_req_t)'({$urandom, $urandom}));
      pick = $urandom_range(0, 99);
      // Weight toward enqueue and select so the rings stay populated.
      if (pick < 30) begin
         r.opcode = OP_ENQUEUE;
      end else if (pick < 45) begin
         r.opcode = OP_DEQUEUE;
      end else if (pick < 55) begin
         r.opcode = OP_YIELD;
      end else if (pick < 75) begin
         r.opcode = OP_SELECT;
      end else if (pick < 85) begin
         r.opcode = OP_SET_LEVEL;
      end else if (pick < 97) begin
         r.opcode = OP_THRESHOLD;
      end else begin
         r.opcode = 3'($urandom_range(6, 7));
      end
      if ($urandom_range(0, 9) < 8) begin
         r.runnable = 1'b1;
      end
      if ($urandom_range(0, 3) != 0) begin
         r.current_valid = 1'b1;
      end
      // Small levels keep several threads sharing a ring.
      if ($urandom_range(0, 3) != 0) begin
         r.new_level = 8'($urandom_range(0, 7));
      end
      if (r.opcode == OP_THRESHOLD && $urandom_range(0, 3) != 0) begin
         r.user_level = 5'($urandom_range(r.new_level[4:0], 31));
         if (r.new_level > 31) begin
            r.new_level = 8'(r.user_level);
         end
         if ($urandom_range(0, 1) != 0) begin
            r.current_id = r.thread_id;
         end
      end
      return r;
   endfunction

   // Receiver: random stall pattern plus one long hold-off.
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   // Result checker and cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("priority_ready_queue_scheduler_tb failed");
         $finish;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("unexpected result item status %0d", rsp_status);
            end
         end else begin
            sched_rsp_t want;
            sched_rsp_t got;
            want = expected_rsps.pop_front();
            got = {rsp_status, rsp_chosen_id, rsp_old_user_threshold, rsp_need_reschedule,
                   rsp_ready_levels, rsp_deferred_levels};
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("result mismatch: expected st=%0d id=%0d old=%0d rs=%0d rdy=%h df=%h",
                           want.status, want.chosen_id, want.old_user_threshold,
                           want.need_reschedule, want.ready_levels, want.deferred_levels);
                  $display("                 actual   st=%0d id=%0d old=%0d rs=%0d rdy=%h df=%h",
                           got.status, got.chosen_id, got.old_user_threshold,
                           got.need_reschedule, got.ready_levels, got.deferred_levels);
               end
            end
         end
      end
   end

   initial begin : hold_off_proc
      int waited;
      wait (!reset);
      repeat (300) @(posedge clock);
      hold_off = 1'b1;
      waited = 0;
      while (waited < 200) begin
         @(posedge clock);
         waited++;
      end
      hold_off = 1'b0;
   end

   initial begin : stimulus
      sched_rsp_t none;
      sched_rsp_t tmp;
      int burst;
      none = '0;
      shadow_ready = '0;
      shadow_deferred = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         shadow_head[i] = '0;
      end
      for (int i = 0; i < NUM_THREADS; i++) begin
         shadow_next[i] = '0;
         shadow_prev[i] = '0;
         shadow_queued[i] = 1'b0;
         shadow_level[i] = 5'(IDLE);
         shadow_eff_thr[i] = 5'(IDLE);
         shadow_user_thr[i] = 5'(IDLE);
      end

      // Directed table.
      add_row(make_req(OP_SELECT, 0, 0, 1, 1, 0, 0, 0), 1,
              fixed_rsp(ST_EMPTY, 0, 32'h0));
      add_row(make_req(OP_ENQUEUE, 31, 0, 0, 0, 0, 0, 0), 1,
              fixed_rsp(ST_NOT_RUN, 0, 32'h0));
      add_row(make_req(OP_DEQUEUE, 5, 0, 0, 1, 0, 0, 0), 1,
              fixed_rsp(ST_NO_EFFECT, 0, 32'h0));
      add_row(make_req(OP_ENQUEUE, 31, 0, 0, 1, 0, 0, 0), 1,
              fixed_rsp(ST_OK, 0, 32'h1));
      add_row(make_req(OP_ENQUEUE, 31, 0, 0, 1, 0, 0, 0), 1,
              fixed_rsp(ST_NO_EFFECT, 0, 32'h1));
      add_row(make_req(OP_SET_LEVEL, 0, 0, 0, 1, 255, 0, 0), 1,
              fixed_rsp(ST_NO_EFFECT, 0, 32'h1));
      add_row(make_req(OP_SET_LEVEL, 0, 0, 0, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_ENQUEUE, 0, 0, 0, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_ENQUEUE, 1, 0, 0, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_SET_LEVEL, 1, 0, 0, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_SET_LEVEL, 1, 0, 0, 0, 3, 0, 0), 0, none);
      add_row(make_req(OP_YIELD, 0, 0, 1, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_YIELD, 0, 31, 1, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_YIELD, 0, 0, 0, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_THRESHOLD, 31, 31, 1, 1, 20, 10, 31), 0, none);
      add_row(make_req(OP_THRESHOLD, 31, 31, 1, 1, 5, 31, 31), 0, none);
      add_row(make_req(OP_SELECT, 0, 31, 1, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_THRESHOLD, 31, 31, 1, 1, 31, 31, 31), 0, none);
      add_row(make_req(OP_THRESHOLD, 31, 31, 1, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_SELECT, 0, 31, 1, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_SELECT, 0, 31, 1, 0, 0, 0, 0), 0, none);
      add_row(make_req(op_type'(3'd6), 2, 0, 0, 1, 0, 0, 0), 0, none);
      add_row(make_req(op_type'(3'd7), 2, 0, 0, 1, 0, 0, 0), 0, none);
      add_row(make_req(OP_DEQUEUE, 0, 0, 0, 1, 0, 0, 0), 0, none);

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         send_item(directed[i].req, directed[i].has_fixed, directed[i].fixed);
      end

      for (int n = 0; n < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst && n < RANDOM_ITEMS; b++) begin
            send_item(random_req(), 0, tmp);
            n++;
         end
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      req_valid <= 1'b0;

      while (expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("priority_ready_queue_scheduler_tb passed");
      end else begin
         $display("priority_ready_queue_scheduler_tb failed");
      end
      $finish;
   end

endmodule
`default_nettype wire
